FILE: rtl/core/prefix_bound_search_assert.svh
// Assertion macros shared by the prefix bound search RTL.
// Include by bare file name; no other dependencies.
`ifndef PREFIX_BOUND_SEARCH_ASSERT_SVH
`define PREFIX_BOUND_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/psb_pkg.sv
// Package for the prefix bound search: word types, field widths, action codes.
// No dependencies.
package psb_pkg;

    localparam int POS_W      = 11;
    localparam int ROW_IDX_W  = 10;
    localparam int IN_WORD_W  = 32;
    localparam int LEN_W      = 3;
    localparam int ACT_W      = 2;
    localparam int MAX_PREFIX = 4;

    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOWER = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPPER = 2'd2;

    localparam logic KIND_LOWER = 1'b0;
    localparam logic KIND_UPPER = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [ROW_IDX_W-1:0] row_index;
        logic [IN_WORD_W-1:0] word0;
        logic [IN_WORD_W-1:0] word1;
        logic [IN_WORD_W-1:0] word2;
        logic [IN_WORD_W-1:0] word3;
        logic [LEN_W-1:0]     prefix_len;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             query_kind;
    } t_out_word;

endpackage

FILE: rtl/core/prefix_bound_search.sv
// Prefix bound search over a table of tuples: top level.
// Depends on psb_pkg, psb_store, psb_search and the assertion header.
//
// Command channel: a word on i_in is taken at a clock edge where start is high
// and busy is low. Action write stores the row at once (no result, busy stays
// low). Action lower or upper bound starts a binary search; action 3 is dropped.
// Configuration: i_cfg_we with i_cfg_data loads row_count; write it only idle.
// Result channel: o_out holds position and query kind, flagged by o_strobe for
// exactly one cycle. The receiver cannot stall it; it must take the word.
// Search: a query with an effective row count N probes the table once per
// cycle (no probes for N = 0), each probe a registered table read feeding one
// tuple compare; the result shows on the cycle after the last probe. The next
// command can be taken in the cycle the result is shown.
// Reset (synchronous, active low) clears row_count and the sequencer; table
// contents are kept and are undefined until written.
`include "prefix_bound_search_assert.svh"

module prefix_bound_search #(
    parameter int ROWS        = 1024,
    parameter int TUPLE_WIDTH = 4,
    parameter int WORD_BITS   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  psb_pkg::t_in_word          i_in,
    input  logic                       i_cfg_we,
    input  logic [psb_pkg::POS_W-1:0]  i_cfg_data,
    output psb_pkg::t_out_word         o_out,
    output logic                       o_strobe
);
    import psb_pkg::*;

    localparam int ADDR_W = $clog2(ROWS);
    localparam int ROW_W  = TUPLE_WIDTH * WORD_BITS;

    logic [POS_W-1:0]      r_row_count;
    logic [POS_W-1:0]      row_count_eff;
    logic                  accept;
    logic                  query_go;
    logic                  wr_en;
    logic [ROW_W-1:0]      wr_row;
    logic [IN_WORD_W-1:0]  wr_word [TUPLE_WIDTH];
    logic [ADDR_W-1:0]     rd_addr;
    logic [ROW_W-1:0]      rd_data;
    logic                  search_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
        end else if (i_cfg_we) begin
            r_row_count <= i_cfg_data;
        end
    end

    assign row_count_eff = (32'(r_row_count) > ROWS) ? POS_W'(ROWS) : r_row_count;

    assign accept   = start && !search_busy;
    assign query_go = accept && ((i_in.action == ACT_LOWER) || (i_in.action == ACT_UPPER));
    assign wr_en    = accept && (i_in.action == ACT_WRITE) && (32'(i_in.row_index) < ROWS);

    // Words past the fourth are stored as zero.
    always_comb begin
        for (int t = 0; t < TUPLE_WIDTH; t++) begin
            case (t)
                0:       wr_word[t] = i_in.word0;
                1:       wr_word[t] = i_in.word1;
                2:       wr_word[t] = i_in.word2;
                3:       wr_word[t] = i_in.word3;
                default: wr_word[t] = '0;
            endcase
            wr_row[t*WORD_BITS +: WORD_BITS] = WORD_BITS'(wr_word[t]);
        end
    end

    psb_store #(
        .DEPTH (ROWS),
        .WIDTH (ROW_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_in.row_index)),
        .i_wdata (wr_row),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    psb_search #(
        .ROWS        (ROWS),
        .TUPLE_WIDTH (TUPLE_WIDTH),
        .WORD_BITS   (WORD_BITS)
    ) u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (query_go),
        .i_query     (i_in),
        .i_row_count (row_count_eff),
        .i_rd_data   (rd_data),
        .o_busy      (search_busy),
        .o_rd_addr   (rd_addr),
        .o_out       (o_out),
        .o_strobe    (o_strobe)
    );

    assign busy = search_busy;

    // A taken query either searches or answers at once.
    `PSB_ASSERT_NEXT(a_query_progress, i_clk, i_rst_n, query_go, search_busy || o_strobe)

endmodule

FILE: rtl/core/psb_store.sv
// Tuple table: one row per entry, one write port, one registered read port.
// Depends on nothing.
module psb_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/psb_search.sv
// Binary search sequencer: one table probe per cycle, next mid chosen from two
// precomputed candidates. Depends on psb_pkg and the assertion header.
`include "prefix_bound_search_assert.svh"

module psb_search #(
    parameter int ROWS        = 1024,
    parameter int TUPLE_WIDTH = 4,
    parameter int WORD_BITS   = 32,
    localparam int ADDR_W     = $clog2(ROWS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  psb_pkg::t_in_word                 i_query,
    input  logic [psb_pkg::POS_W-1:0]         i_row_count,
    input  logic [TUPLE_WIDTH*WORD_BITS-1:0]  i_rd_data,
    output logic                              o_busy,
    output logic [ADDR_W-1:0]                 o_rd_addr,
    output psb_pkg::t_out_word                o_out,
    output logic                              o_strobe
);
    import psb_pkg::*;

    localparam int LIM = (TUPLE_WIDTH < MAX_PREFIX) ? TUPLE_WIDTH : MAX_PREFIX;

    typedef enum logic {ST_IDLE, ST_SEARCH} t_state;

    t_state                r_state;
    logic [POS_W-1:0]      r_left;
    logic [POS_W-1:0]      r_right;
    logic [POS_W-1:0]      r_mid;
    logic [WORD_BITS-1:0]  r_prefix [LIM];
    logic [LEN_W-1:0]      r_len;
    logic                  r_upper;
    t_out_word             r_out;
    logic                  r_strobe;

    logic [IN_WORD_W-1:0]  q_word [LIM];
    logic [LEN_W-1:0]      q_len;
    logic                  cmp_lt;
    logic                  cmp_gt;
    logic                  go_left;
    logic [POS_W-1:0]      lo_mid;
    logic                  lo_more;
    logic [POS_W-1:0]      hi_left;
    logic [POS_W-1:0]      hi_mid;
    logic                  hi_more;
    logic [POS_W-1:0]      n_left;
    logic [POS_W-1:0]      n_right;
    logic [POS_W-1:0]      n_mid;
    logic                  n_more;
    logic [POS_W-1:0]      ent_mid;

    always_comb begin
        for (int i = 0; i < LIM; i++) begin
            case (i)
                0:       q_word[i] = i_query.word0;
                1:       q_word[i] = i_query.word1;
                2:       q_word[i] = i_query.word2;
                3:       q_word[i] = i_query.word3;
                default: q_word[i] = '0;
            endcase
        end
    end

    assign q_len = (32'(i_query.prefix_len) > LIM) ? LEN_W'(LIM) : i_query.prefix_len;

    // Lexicographic compare over the first r_len words; lowest differing word wins.
    always_comb begin
        cmp_lt = 1'b0;
        cmp_gt = 1'b0;
        for (int i = LIM - 1; i >= 0; i--) begin
            if ((i < 32'(r_len)) &&
                (i_rd_data[i*WORD_BITS +: WORD_BITS] != r_prefix[i])) begin
                cmp_lt = i_rd_data[i*WORD_BITS +: WORD_BITS] < r_prefix[i];
                cmp_gt = !cmp_lt;
            end
        end
    end

    assign go_left = r_upper ? cmp_gt : !cmp_lt;

    // Both possible next intervals are worked out ahead of the compare.
    assign lo_mid  = r_left + ((r_mid - r_left) >> 1);
    assign lo_more = r_left < r_mid;
    assign hi_left = r_mid + POS_W'(1);
    assign hi_mid  = hi_left + ((r_right - hi_left) >> 1);
    assign hi_more = hi_left < r_right;

    assign n_left  = go_left ? r_left  : hi_left;
    assign n_right = go_left ? r_mid   : r_right;
    assign n_mid   = go_left ? lo_mid  : hi_mid;
    assign n_more  = go_left ? lo_more : hi_more;

    assign ent_mid   = i_row_count >> 1;
    assign o_rd_addr = ADDR_W'((r_state == ST_SEARCH) ? n_mid : ent_mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_go) begin
                        r_left  <= '0;
                        r_right <= i_row_count;
                        r_mid   <= ent_mid;
                        r_len   <= q_len;
                        r_upper <= (i_query.action == ACT_UPPER);
                        for (int i = 0; i < LIM; i++) begin
                            r_prefix[i] <= WORD_BITS'(q_word[i]);
                        end
                        if (i_row_count != '0) begin
                            r_state <= ST_SEARCH;
                        end else begin
                            r_strobe         <= 1'b1;
                            r_out.position   <= '0;
                            r_out.query_kind <= (i_query.action == ACT_UPPER) ?
                                                KIND_UPPER : KIND_LOWER;
                        end
                    end
                end
                ST_SEARCH: begin
                    r_left  <= n_left;
                    r_right <= n_right;
                    r_mid   <= n_mid;
                    if (!n_more) begin
                        r_state          <= ST_IDLE;
                        r_strobe         <= 1'b1;
                        r_out.position   <= n_left;
                        r_out.query_kind <= r_upper ? KIND_UPPER : KIND_LOWER;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state == ST_SEARCH);
    assign o_out    = r_out;
    assign o_strobe = r_strobe;

    `PSB_ASSERT_NOW(a_interval_open, i_clk, i_rst_n, o_busy, r_left < r_right)
    `PSB_ASSERT_NOW(a_mid_in_range, i_clk, i_rst_n, o_busy, r_left <= r_mid && r_mid < r_right)

endmodule
